>>> hw/rtl/laplacian_mesh_smoother_assert.svh
// Assertion macros for the Laplacian mesh smoother checker.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef LAPLACIAN_MESH_SMOOTHER_ASSERT_SVH
`define LAPLACIAN_MESH_SMOOTHER_ASSERT_SVH

// Checks a property on every clock edge outside of reset.
`define LMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every clock edge, during reset too.
`define LMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/lms_pkg.sv
// Shared types and codes of the Laplacian mesh smoother.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package lms_pkg;

  localparam int NODE_W  = 10;
  localparam int COORD_W = 32;
  localparam int ITER_W  = 16;
  localparam int MOVE_W  = 64;
  localparam int EXT_W   = 17;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_DONE    = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_MAX_ITER  = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e                        op;
    logic [NODE_W-1:0]          node;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic                       pinned;
    logic [NODE_W-1:0]          neighbour;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0]          out_node;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic [ITER_W-1:0]          passes_done;
    logic [MOVE_W-1:0]          last_max_move;
    status_e                    status;
  } out_t;

  typedef struct packed {
    logic item_load;
    logic clr_en;
    logic run_start;
    logic item_exec;
    logic pass_init;
    logic node_rd;
    logic node_chk;
    logic k_wait;
    logic k_acc;
    logic div_start;
    logic diff;
    logic sq_x;
    logic sq_y;
    logic upd_max;
    logic node_next;
    logic pass_end;
    logic run_done;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic item_is_run;
    logic i_last;
    logic skip_node;
    logic k_last;
    logic div_busy;
    logic run_more;
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/lms_div.sv
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on lms_pkg for the coordinate width.
`timescale 1ns / 1ps
`default_nettype none

module lms_div import lms_pkg::*; #(
  parameter int SW = 36,
  parameter int DW = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SW-1:0]      dividend_i,
  input  logic [DW-1:0]             divisor_i,
  output logic                      busy_o,
  output logic signed [COORD_W-1:0] quot_o
);

  localparam int CW = $clog2(SW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, div_q;
  logic [SW-1:0] quo_q, quo_neg;
  logic          neg_q;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh  = {rem_q, quo_q[SW-1]};
  assign fits    = rem_sh >= {1'b0, div_q};
  assign quo_neg = ~quo_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(SW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[SW-1];
      quo_q <= dividend_i[SW-1] ? (~dividend_i + 1'b1) : dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(rem_sh - {1'b0, div_q}) : rem_sh[DW-1:0];
      quo_q <= {quo_q[SW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? quo_neg[COORD_W-1:0] : quo_q[COORD_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/lms_ctrl.sv
// Controller state machine of the Laplacian mesh smoother.
// Depends on lms_pkg; drives the datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
`default_nettype none

module lms_ctrl import lms_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [18:0] {
    S_CLEAR     = 19'h00001,
    S_IDLE      = 19'h00002,
    S_ITEM_RD   = 19'h00004,
    S_ITEM_EXEC = 19'h00008,
    S_PASS_INIT = 19'h00010,
    S_NODE_RD   = 19'h00020,
    S_NODE_CHK  = 19'h00040,
    S_K_RD      = 19'h00080,
    S_K_WAIT    = 19'h00100,
    S_K_ACC     = 19'h00200,
    S_DIV_GO    = 19'h00400,
    S_DIV       = 19'h00800,
    S_DIFF      = 19'h01000,
    S_SQ_X      = 19'h02000,
    S_SQ_Y      = 19'h04000,
    S_MAX       = 19'h08000,
    S_NODE_NEXT = 19'h10000,
    S_PASS_END  = 19'h20000,
    S_RUN_DONE  = 19'h40000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.i_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_ITEM_RD;
        end
      end
      S_ITEM_RD: begin
        if (stat_i.item_is_run) begin
          cmd_o.run_start = 1'b1;
          state_d         = S_PASS_INIT;
        end else begin
          state_d = S_ITEM_EXEC;
        end
      end
      S_ITEM_EXEC: begin
        cmd_o.item_exec = 1'b1;
        state_d         = S_IDLE;
      end
      S_PASS_INIT: begin
        cmd_o.pass_init = 1'b1;
        state_d         = S_NODE_RD;
      end
      S_NODE_RD: begin
        cmd_o.node_rd = 1'b1;
        state_d       = S_NODE_CHK;
      end
      S_NODE_CHK: begin
        cmd_o.node_chk = 1'b1;
        state_d        = stat_i.skip_node ? S_NODE_NEXT : S_K_RD;
      end
      S_K_RD: begin
        state_d = S_K_WAIT;
      end
      S_K_WAIT: begin
        cmd_o.k_wait = 1'b1;
        state_d      = S_K_ACC;
      end
      S_K_ACC: begin
        cmd_o.k_acc = 1'b1;
        state_d     = stat_i.k_last ? S_DIV_GO : S_K_RD;
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (!stat_i.div_busy) state_d = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_SQ_X;
      end
      S_SQ_X: begin
        cmd_o.sq_x = 1'b1;
        state_d    = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd_o.sq_y = 1'b1;
        state_d    = S_MAX;
      end
      S_MAX: begin
        cmd_o.upd_max = 1'b1;
        state_d       = S_NODE_NEXT;
      end
      S_NODE_NEXT: begin
        cmd_o.node_next = 1'b1;
        state_d         = stat_i.i_last ? S_PASS_END : S_NODE_RD;
      end
      S_PASS_END: begin
        cmd_o.pass_end = 1'b1;
        state_d        = stat_i.run_more ? S_PASS_INIT : S_RUN_DONE;
      end
      S_RUN_DONE: begin
        cmd_o.run_done = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lms_datapath.sv
// Datapath of the Laplacian mesh smoother: mesh memories, accumulators,
// dividers, squared-move unit, configuration and result registers.
// Depends on lms_pkg and lms_div.
`timescale 1ns / 1ps
`default_nettype none

module lms_datapath import lms_pkg::*; #(
  parameter int NODE_COUNT = 1024,
  parameter int MAX_DEGREE = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_t               in_data_i,
  input  logic              out_ready_i,
  input  logic              cfg_valid_i,
  input  cfg_idx_e          cfg_index_i,
  input  logic [MOVE_W-1:0] cfg_data_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic              out_valid_o,
  output out_t              out_data_o
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int KW = $clog2(MAX_DEGREE);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int SW = COORD_W + DW;
  localparam int MW = DW + 1;

  logic [MW-1:0]      meta_mem [2**NW];
  logic [NW-1:0]      nbr_mem  [2**(NW+KW)];
  logic [COORD_W-1:0] px_mem   [2**(NW+1)];
  logic [COORD_W-1:0] py_mem   [2**(NW+1)];

  logic [ITER_W-1:0]  max_iter_q;
  logic [MOVE_W-1:0]  thr_q;
  in_t                item_q;
  logic               bank_q;
  logic [NW-1:0]      i_q;
  logic [DW-1:0]      k_q, deg_q;
  logic [ITER_W-1:0]  pass_q, passes_q;
  logic [MOVE_W-1:0]  worst_q, last_move_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [MW-1:0]             meta_rd_q;
  logic [NW-1:0]             nbr_rd_q;
  logic signed [COORD_W-1:0] px_rd_q, py_rd_q, own_x_q, own_y_q;
  logic signed [SW-1:0]      sx_q, sy_q;
  logic [COORD_W-1:0]        ax_q, ay_q;
  logic [MOVE_W-1:0]         sqx_q, sqy_q;

  logic [EXT_W-1:0]          node_ext, nb_ext;
  logic                      node_ok, nb_ok;
  logic [NW-1:0]             node_idx, nb_idx;
  logic [DW-1:0]             rd_deg;
  logic                      rd_fixed, add_ok;
  logic [NW-1:0]             meta_ra;
  logic [NW:0]               pos_ra, pos_wa;
  logic                      pos_we, meta_we, nbr_we;
  logic [COORD_W-1:0]        pos_wx, pos_wy;
  logic [NW-1:0]             meta_wa;
  logic [MW-1:0]             meta_wd;
  logic signed [COORD_W-1:0] nx, ny;
  logic                      busy_x, busy_y;
  logic signed [COORD_W:0]   dx, dy;
  logic [MOVE_W:0]           sq_sum;
  logic [MOVE_W-1:0]         sq_sat;
  logic [ITER_W-1:0]         limit;

  assign node_ext = {{(EXT_W-NODE_W){1'b0}}, item_q.node};
  assign nb_ext   = {{(EXT_W-NODE_W){1'b0}}, item_q.neighbour};
  assign node_ok  = node_ext < EXT_W'(NODE_COUNT);
  assign nb_ok    = nb_ext < EXT_W'(NODE_COUNT);
  assign node_idx = node_ext[NW-1:0];
  assign nb_idx   = nb_ext[NW-1:0];
  assign rd_deg   = meta_rd_q[DW-1:0];
  assign rd_fixed = meta_rd_q[DW];
  assign add_ok   = node_ok && nb_ok && (rd_deg < DW'(MAX_DEGREE));
  assign limit    = (max_iter_q == '0) ? ITER_W'(1) : max_iter_q;

  // Read address selection for the metadata and position memory read ports.
  assign meta_ra = cmd_i.node_rd ? i_q : node_idx;
  always_comb begin
    priority if (cmd_i.k_wait) begin
      pos_ra = {bank_q, nbr_rd_q};
    end else if (cmd_i.node_rd) begin
      pos_ra = {bank_q, i_q};
    end else begin
      pos_ra = {bank_q, node_idx};
    end
  end

  // Position write port: node loads go to the current bank, pass results to the other.
  always_comb begin
    pos_we = 1'b0;
    pos_wa = {bank_q, node_idx};
    pos_wx = item_q.pos_x;
    pos_wy = item_q.pos_y;
    priority if (cmd_i.item_exec) begin
      pos_we = (item_q.op == OP_WRITE) && node_ok;
    end else if (cmd_i.node_chk) begin
      pos_we = rd_fixed || (rd_deg == '0);
      pos_wa = {~bank_q, i_q};
      pos_wx = px_rd_q;
      pos_wy = py_rd_q;
    end else if (cmd_i.diff) begin
      pos_we = 1'b1;
      pos_wa = {~bank_q, i_q};
      pos_wx = nx;
      pos_wy = ny;
    end else begin
      pos_we = 1'b0;
    end
  end

  always_comb begin
    meta_we = 1'b0;
    meta_wa = node_idx;
    meta_wd = {item_q.pinned, {DW{1'b0}}};
    priority if (cmd_i.clr_en) begin
      meta_we = 1'b1;
      meta_wa = i_q;
      meta_wd = '0;
    end else if (cmd_i.item_exec && item_q.op == OP_WRITE) begin
      meta_we = node_ok;
    end else if (cmd_i.item_exec && item_q.op == OP_ADD) begin
      meta_we = add_ok;
      meta_wd = {rd_fixed, DW'(rd_deg + 1'b1)};
    end else begin
      meta_we = 1'b0;
    end
  end

  assign nbr_we = cmd_i.item_exec && (item_q.op == OP_ADD) && add_ok;

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (nbr_we) nbr_mem[{node_idx, rd_deg[KW-1:0]}] <= nb_idx;
    if (pos_we) begin
      px_mem[pos_wa] <= pos_wx;
      py_mem[pos_wa] <= pos_wy;
    end
    meta_rd_q <= meta_mem[meta_ra];
    nbr_rd_q  <= nbr_mem[{i_q, k_q[KW-1:0]}];
    px_rd_q   <= px_mem[pos_ra];
    py_rd_q   <= py_mem[pos_ra];
  end

  lms_div #(.SW(SW), .DW(DW)) u_div_x (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(sx_q),
    .divisor_i(deg_q), .busy_o(busy_x), .quot_o(nx)
  );

  lms_div #(.SW(SW), .DW(DW)) u_div_y (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(sy_q),
    .divisor_i(deg_q), .busy_o(busy_y), .quot_o(ny)
  );

  assign dx     = {nx[COORD_W-1], nx} - {own_x_q[COORD_W-1], own_x_q};
  assign dy     = {ny[COORD_W-1], ny} - {own_y_q[COORD_W-1], own_y_q};
  assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign sq_sat = sq_sum[MOVE_W] ? {MOVE_W{1'b1}} : sq_sum[MOVE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) item_q <= in_data_i;
    if (cmd_i.node_chk) begin
      deg_q   <= rd_deg;
      own_x_q <= px_rd_q;
      own_y_q <= py_rd_q;
      sx_q    <= '0;
      sy_q    <= '0;
    end
    if (cmd_i.k_acc) begin
      sx_q <= sx_q + SW'(px_rd_q);
      sy_q <= sy_q + SW'(py_rd_q);
    end
    if (cmd_i.diff) begin
      ax_q <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ay_q <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    end
    if (cmd_i.sq_x) sqx_q <= ax_q * ax_q;
    if (cmd_i.sq_y) sqy_q <= ay_q * ay_q;
    if (cmd_i.item_exec) begin
      out_q.out_node      <= item_q.node;
      out_q.out_x         <= (item_q.op == OP_READ && node_ok) ? px_rd_q : '0;
      out_q.out_y         <= (item_q.op == OP_READ && node_ok) ? py_rd_q : '0;
      out_q.passes_done   <= passes_q;
      out_q.last_max_move <= last_move_q;
      out_q.status        <= (item_q.op == OP_ADD && node_ok && !add_ok) ?
                             STATUS_IGNORED : STATUS_OK;
    end else if (cmd_i.run_done) begin
      out_q.out_node      <= '0;
      out_q.out_x         <= '0;
      out_q.out_y         <= '0;
      out_q.passes_done   <= pass_q;
      out_q.last_max_move <= worst_q;
      out_q.status        <= STATUS_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q  <= ITER_W'(100);
      thr_q       <= MOVE_W'(4295);
      bank_q      <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      pass_q      <= '0;
      worst_q     <= '0;
      passes_q    <= '0;
      last_move_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MAX_ITER:  max_iter_q <= cfg_data_i[ITER_W-1:0];
          CFG_THRESHOLD: thr_q      <= cfg_data_i;
          default:       thr_q      <= thr_q;
        endcase
      end
      if (cmd_i.clr_en || cmd_i.node_next) begin
        i_q <= stat_o.i_last ? '0 : NW'(i_q + 1'b1);
      end else if (cmd_i.pass_init) begin
        i_q <= '0;
      end
      if (cmd_i.node_chk) k_q <= '0;
      else if (cmd_i.k_acc) k_q <= DW'(k_q + 1'b1);
      if (cmd_i.run_start) pass_q <= '0;
      else if (cmd_i.pass_init) pass_q <= ITER_W'(pass_q + 1'b1);
      if (cmd_i.pass_init) worst_q <= '0;
      else if (cmd_i.upd_max && sq_sat > worst_q) worst_q <= sq_sat;
      if (cmd_i.pass_end) bank_q <= ~bank_q;
      if (cmd_i.run_done) begin
        passes_q    <= pass_q;
        last_move_q <= worst_q;
      end
      if (cmd_i.item_exec || cmd_i.run_done) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    stat_o.out_busy    = out_valid_q && !out_ready_i;
    stat_o.item_is_run = item_q.op == OP_RUN;
    stat_o.i_last      = i_q == NW'(NODE_COUNT - 1);
    stat_o.skip_node   = rd_fixed || (rd_deg == '0);
    stat_o.k_last      = DW'(k_q + 1'b1) == deg_q;
    stat_o.div_busy    = busy_x || busy_y;
    stat_o.run_more    = (pass_q < limit) && (worst_q > thr_q);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/laplacian_mesh_smoother.sv
// Laplacian mesh smoother: input, result and configuration channels
// with valid/ready handshakes. Instantiates lms_ctrl and lms_datapath; imports lms_pkg.
//
// Usage: each input transaction carries one command. Op 0 loads a node's
// position and fixed flag and empties its neighbour list, op 1 appends a
// neighbour, op 2 runs Jacobi smoothing passes, op 3 reads a node back.
// Every command yields exactly one result transaction.
// Loads, neighbour adds and reads pass through the item read and execute
// states before the result register is written. A run makes passes over all
// nodes, copying each fixed or isolated node and averaging the neighbours of
// each free node; the bit-serial divide of the neighbour sum dominates its work.
// Configuration writes go straight into their registers and must only be
// issued while the block is idle.
// After reset the neighbour counts are cleared one node per cycle; no command
// is accepted until that finishes.
// The result sits in an output register; a stalled receiver holds it, and
// no new command is accepted until that result is taken or is being taken.
`timescale 1ns / 1ps
`default_nettype none

module laplacian_mesh_smoother import lms_pkg::*; #(
  parameter int NODE_COUNT = 1024,
  parameter int MAX_DEGREE = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  cfg_idx_e          cfg_index_i,
  input  logic [MOVE_W-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  lms_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .stat_i(stat), .cmd_o(cmd)
  );

  lms_datapath #(.NODE_COUNT(NODE_COUNT), .MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .out_ready_i, .cfg_valid_i, .cfg_index_i,
    .cfg_data_i, .cmd_i(cmd), .stat_o(stat), .out_valid_o, .out_data_o
  );

endmodule

`default_nettype wire

>>> hw/rtl/lms_checker.sv
// Port-level checker for the Laplacian mesh smoother, bound to the top level.
// Depends on lms_pkg and laplacian_mesh_smoother_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "laplacian_mesh_smoother_assert.svh"

module lms_checker import lms_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  `LMS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `LMS_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o), "result changed")
  `LMS_ASSERT(a_one_pending, in_valid_i && in_ready_o |-> !(out_valid_o && !out_ready_i), "accepted over a pending result")
  `LMS_ASSERT(a_item_latency, in_valid_i && in_ready_o && in_data_i.op != OP_RUN |-> ##3 out_valid_o, "late result")
  `LMS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result during reset")

endmodule

bind laplacian_mesh_smoother lms_checker u_lms_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .out_data_o(out_data_o)
);

`default_nettype wire
